>>> rtl/core/lp_shrink_operator_unit_macros.svh
// assertion helpers for the shrink operator unit
`ifndef LP_SHRINK_OPERATOR_UNIT_MACROS_SVH
`define LP_SHRINK_OPERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LPSO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LPSO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lpso_pkg.sv
package lpso_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int BETA_STEPS  = 3;
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic CFG_P_EXP = 1'b0;
	localparam logic CFG_MU    = 1'b1;

	localparam logic [15:0] P_RESET  = 16'd26214;
	localparam logic [31:0] MU_RESET = 32'd655360;

	localparam logic [63:0] LOG_ONE  = 64'h0000_0001_0000_0000;
	localparam logic [63:0] LOG_16   = 64'h0000_0010_0000_0000;
	localparam logic [63:0] LOG_30   = 64'h0000_001E_0000_0000;
	localparam logic [30:0] BETA_ONE = 31'h4000_0000;
	localparam logic [30:0] BETA_FLOOR = 31'd11;
	localparam logic [63:0] BETA_HALF  = 64'h2000_0000;
	localparam logic [63:0] CAP_Q16  = 64'h0001_0000_0000_0000;
	localparam logic [63:0] CAP_TERM = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res_x;
		logic signed [DATA_WIDTH-1:0] res_y;
		logic signed [DATA_WIDTH-1:0] res_z;
	} res_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] out_x;
		logic signed [DATA_WIDTH-1:0] out_y;
		logic signed [DATA_WIDTH-1:0] out_z;
		logic                         zeroed;
	} result_t;

	typedef struct packed {
		logic [2:0][DATA_WIDTH-1:0] mag;
		logic [2:0]                 neg;
		logic [63:0]                sumsq;
	} qent_t;

	typedef enum logic [1:0] {OP_SQRT, OP_DIV, OP_LG, OP_EXP} iter_op_t;

	typedef struct packed {
		logic        start;
		iter_op_t    op;
		logic [63:0] a;
		logic [63:0] b;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} iter_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, C_LGM, C_LGD, C_DIV, C_ALPHA, C_LGP, C_EXPT,
		I_SQRT, I_CMP, I_DIV, I_LGN, I_MN, I_LGB, I_EXPB, I_OUT
	} seq_state_t;

	// elaboration only: floor square root
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = v;
		for (int n = 0; n < 32; n++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// factor 2^(2^-(j+1)) in Q1.31
	function automatic logic [31:0] exp_fact(input int j);
		logic [63:0] c;
		c = LOG_ONE;
		for (int n = 0; n <= j; n++) c = isqrt64(c << 31);
		return c[31:0];
	endfunction

	// a * f / 65536, truncated toward zero
	function automatic logic signed [63:0] mul16(input logic signed [63:0] a,
		input logic signed [18:0] f);
		logic        neg;
		logic [63:0] ma, r;
		logic [18:0] fm;
		neg = a[63] ^ f[18];
		ma  = a[63] ? (~a + 64'd1) : a;
		fm  = f[18] ? (~f + 19'd1) : f;
		r   = 64'(ma * {45'd0, fm}) >> 16;
		return neg ? -$signed(r) : $signed(r);
	endfunction

endpackage

>>> rtl/core/lp_shrink_operator_unit.sv
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------
// input     | start / busy       | res (res_x, res_y, res_z)
// result    | done strobe        | result (out_x, out_y, out_z, zeroed)
// config    | cfg_we             | cfg_idx, cfg_wdata
//
// an item passes through the shared iterative unit (square root, divide, log and
// exponent, one bit per cycle); the divide is skipped when alpha is not below the norm,
// the beta steps when p is zero; a zeroed item stops after the square root and compare.
// the front queue holds four items while the back works. after reset and after every
// register write the constants are recomputed before the next queued item is started.
// done is high for one cycle per item.
module lp_shrink_operator_unit #(
	parameter int BETA_STEPS = lpso_pkg::BETA_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lpso_pkg::res_t      res,
	output logic                done,
	output lpso_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [31:0]         cfg_wdata
);
	logic [15:0]         p_q;
	logic [31:0]         mu_q;
	logic                q_valid, q_pop;
	lpso_pkg::qent_t     q_head;
	lpso_pkg::iter_req_t iter_req;
	lpso_pkg::iter_rsp_t iter_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= lpso_pkg::P_RESET;
			mu_q <= lpso_pkg::MU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lpso_pkg::CFG_P_EXP: p_q  <= cfg_wdata[15:0];
				lpso_pkg::CFG_MU:    mu_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lpso_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.res     (res),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	lpso_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.rsp    (iter_rsp)
	);

	lpso_back #(
		.BETA_STEPS (BETA_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_p    (p_q),
		.cfg_mu   (mu_q),
		.cfg_wr   (cfg_we),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.iter_req (iter_req),
		.iter_rsp (iter_rsp),
		.done     (done),
		.result   (result)
	);

endmodule

>>> rtl/core/lpso_front.sv
module lpso_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lpso_pkg::res_t      res,
	output logic                q_valid,
	output lpso_pkg::qent_t     q_head,
	input  logic                q_pop
);
	localparam int DW = lpso_pkg::DATA_WIDTH;
	localparam int QD = lpso_pkg::QUEUE_DEPTH;
	localparam int QA = $clog2(QD);
	localparam int QC = $clog2(QD + 1);

	logic [2:0][DW-1:0] mag_c, mag_s1;
	logic [2:0]         neg_c, neg_s1;
	logic               v_s1;
	logic               accept;
	logic [63:0]        sumsq;
	lpso_pkg::qent_t    mem_q [QD];
	logic [QA-1:0]      wp_q, rp_q;
	logic [QC-1:0]      cnt_q;

	// stage one holds a slot, so count it as taken
	assign busy   = (32'(cnt_q) + 32'(v_s1)) >= QD;
	assign accept = start && !busy;

	always_comb begin
		neg_c[0] = res.res_x[DW-1];
		neg_c[1] = res.res_y[DW-1];
		neg_c[2] = res.res_z[DW-1];
		mag_c[0] = neg_c[0] ? (~res.res_x + DW'(1)) : res.res_x;
		mag_c[1] = neg_c[1] ? (~res.res_y + DW'(1)) : res.res_y;
		mag_c[2] = neg_c[2] ? (~res.res_z + DW'(1)) : res.res_z;
	end

	always_comb begin
		sumsq = '0;
		for (int j = 0; j < 3; j++)
			sumsq = sumsq + 64'(64'(mag_s1[j]) * 64'(mag_s1[j]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem_q[wp_q].mag   <= mag_s1;
			mem_q[wp_q].neg   <= neg_s1;
			mem_q[wp_q].sumsq <= sumsq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (v_s1)
				wp_q <= (wp_q == QA'(QD - 1)) ? '0 : wp_q + QA'(1);
			if (q_pop)
				rp_q <= (rp_q == QA'(QD - 1)) ? '0 : rp_q + QA'(1);
			cnt_q <= cnt_q + QC'(v_s1) - QC'(q_pop);
		end
	end

	assign q_valid = cnt_q != '0;
	assign q_head  = mem_q[rp_q];

endmodule

>>> rtl/core/lpso_iter.sv
module lpso_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  lpso_pkg::iter_req_t req,
	output lpso_pkg::iter_rsp_t rsp
);
	logic                run_q;
	lpso_pkg::iter_op_t  op_q;
	logic [6:0]          cnt_q;
	logic [63:0]         x_q, z_q, w_q;
	logic [64:0]         y_q;
	logic                done_q;
	logic [63:0]         res_q;
	logic [31:0]         fact [32];

	logic [5:0]          lg_k;
	logic [63:0]         lg_norm;
	logic [63:0]         x_n, z_n;
	logic [64:0]         y_n;
	logic [6:0]          last;
	logic [63:0]         fin;
	logic [63:0]         sq, sum, mm;
	logic [32:0]         t;
	logic [64:0]         rem;
	logic                ge;
	logic signed [63:0]  ei, esh;

	for (genvar g = 0; g < 32; g++) begin : g_fact
		localparam logic [31:0] F = lpso_pkg::exp_fact(g);
		assign fact[g] = F;
	end

	// top set bit and mantissa for the log setup
	always_comb begin
		lg_k = '0;
		for (int n = 0; n < 64; n++)
			if (req.a[n]) lg_k = 6'(n);
		lg_norm = (lg_k > 6'd31) ? (req.a >> (lg_k - 6'd31)) : (req.a << (6'd31 - lg_k));
	end

	always_comb begin
		x_n  = x_q;
		y_n  = y_q;
		z_n  = z_q;
		fin  = '0;
		sq   = '0;
		sum  = '0;
		mm   = '0;
		t    = '0;
		rem  = '0;
		ge   = 1'b0;
		ei   = $signed(z_q);
		esh  = '0;
		last = 7'd31;
		unique case (op_q)
			lpso_pkg::OP_SQRT: begin
				sum = y_q[63:0] + z_q;
				if (x_q >= sum) begin
					x_n = x_q - sum;
					y_n = {1'b0, (y_q[63:0] >> 1) + z_q};
				end else begin
					y_n = {1'b0, y_q[63:0] >> 1};
				end
				z_n = z_q >> 2;
				fin = y_n[63:0];
			end
			lpso_pkg::OP_DIV: begin
				last = 7'd63;
				rem  = {y_q[63:0], x_q[63]};
				ge   = rem >= {1'b0, z_q};
				y_n  = ge ? rem - {1'b0, z_q} : rem;
				x_n  = {x_q[62:0], ge};
				fin  = x_n;
			end
			lpso_pkg::OP_LG: begin
				sq  = 64'(x_q[31:0] * x_q[31:0]);
				t   = sq[63:31];
				y_n = {y_q[63:0], t[32]};
				x_n = t[32] ? {32'd0, t[32:1]} : {32'd0, t[31:0]};
				fin = {z_q[31:0], y_n[31:0]};
			end
			lpso_pkg::OP_EXP: begin
				last = 7'd32;
				if (cnt_q != 7'd32) begin
					if (y_q[31]) begin
						sq  = 64'(x_q[31:0] * fact[cnt_q[4:0]]);
						x_n = sq >> 31;
					end
					y_n = y_q << 1;
				end
				// final scaling by the integer part, saturating at the cap
				if (ei < 64'sd31) begin
					esh = 64'sd31 - ei;
					fin = (esh >= 64'sd64) ? '0 : (x_q >> esh[5:0]);
				end else begin
					esh = ei - 64'sd31;
					if (esh >= 64'sd32) begin
						fin = w_q;
					end else begin
						mm  = x_q << esh[4:0];
						fin = (mm > w_q) ? w_q : mm;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= lpso_pkg::OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				cnt_q <= '0;
				if (req.op == lpso_pkg::OP_LG && req.a == '0) begin
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			unique case (req.op)
				lpso_pkg::OP_SQRT: begin
					x_q <= req.a;
					y_q <= '0;
					z_q <= 64'h4000_0000_0000_0000;
				end
				lpso_pkg::OP_DIV: begin
					x_q <= req.a;
					y_q <= '0;
					z_q <= req.b;
				end
				lpso_pkg::OP_LG: begin
					x_q <= {32'd0, lg_norm[31:0]};
					y_q <= '0;
					z_q <= {58'd0, lg_k};
				end
				lpso_pkg::OP_EXP: begin
					x_q <= 64'h8000_0000;
					y_q <= {33'd0, req.a[31:0]};
					z_q <= 64'($signed(req.a) >>> 32);
					w_q <= req.b;
				end
				default: ;
			endcase
			res_q <= '0;
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (cnt_q == last)
				res_q <= fin;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

>>> rtl/core/lpso_back.sv
module lpso_back #(
	parameter int BETA_STEPS = lpso_pkg::BETA_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         cfg_p,
	input  logic [31:0]         cfg_mu,
	input  logic                cfg_wr,
	input  logic                q_valid,
	input  lpso_pkg::qent_t     q_head,
	output logic                q_pop,
	output lpso_pkg::iter_req_t iter_req,
	input  lpso_pkg::iter_rsp_t iter_rsp,
	output logic                done,
	output lpso_pkg::result_t   result
);
	localparam int DW = lpso_pkg::DATA_WIDTH;
	localparam int SW = $clog2(BETA_STEPS + 1);

	lpso_pkg::seq_state_t state_q, state_n;
	logic                 dirty_q, pend_q, done_q;
	logic [SW-1:0]        step_q;
	lpso_pkg::qent_t      item_q;
	lpso_pkg::result_t    result_q;
	logic signed [63:0]   lgm_q, n_q, la_q, lpm_q, lnorm_q, mn2_q, lb_q;
	logic [63:0]          alpha_q, thr_q, norm_q;
	logic [30:0]          beta_q;

	logic [31:0]          mx;
	logic [63:0]          n_mag, rv, term;
	logic signed [18:0]   pm1, pm2;
	logic                 call, zero_hit, p_zero;
	logic [2:0][63:0]     rmag;

	assign mx     = (cfg_mu == '0) ? 32'd1 : cfg_mu;
	assign pm1    = $signed({3'd0, cfg_p}) - 19'sd65536;
	assign pm2    = $signed({3'd0, cfg_p}) - 19'sd131072;
	assign p_zero = cfg_p == '0;
	assign n_mag  = n_q[63] ? (~n_q + 64'd1) : n_q;
	assign rv     = iter_rsp.res;
	assign term   = iter_rsp.res;
	assign zero_hit = (norm_q == '0) || (norm_q <= thr_q);

	always_comb begin
		for (int j = 0; j < 3; j++)
			rmag[j] = 64'(64'(item_q.mag[j]) * {33'd0, beta_q} + lpso_pkg::BETA_HALF) >> 30;
	end

	// operand select for the shared unit
	always_comb begin
		call         = 1'b1;
		iter_req.op  = lpso_pkg::OP_LG;
		iter_req.a   = '0;
		iter_req.b   = '0;
		unique case (state_q)
			lpso_pkg::C_LGM: iter_req.a = {32'd0, mx};
			lpso_pkg::C_LGD: iter_req.a = {47'd0, 17'h10000 - {1'b0, cfg_p}};
			lpso_pkg::C_DIV: begin
				iter_req.op = lpso_pkg::OP_DIV;
				iter_req.a  = n_mag << 16;
				iter_req.b  = {46'd0, 18'h20000 - {2'd0, cfg_p}};
			end
			lpso_pkg::C_ALPHA: begin
				iter_req.op = lpso_pkg::OP_EXP;
				iter_req.a  = la_q + lpso_pkg::LOG_16;
				iter_req.b  = lpso_pkg::CAP_Q16;
			end
			lpso_pkg::C_LGP: iter_req.a = {48'd0, cfg_p};
			lpso_pkg::C_EXPT: begin
				iter_req.op = lpso_pkg::OP_EXP;
				iter_req.a  = lpm_q + lpso_pkg::mul16(la_q, pm1) + lpso_pkg::LOG_16;
				iter_req.b  = lpso_pkg::CAP_Q16;
			end
			lpso_pkg::I_SQRT: begin
				iter_req.op = lpso_pkg::OP_SQRT;
				iter_req.a  = item_q.sumsq;
			end
			lpso_pkg::I_DIV: begin
				iter_req.op = lpso_pkg::OP_DIV;
				iter_req.a  = alpha_q << 30;
				iter_req.b  = norm_q;
			end
			lpso_pkg::I_LGN: iter_req.a = norm_q;
			lpso_pkg::I_LGB: iter_req.a = {33'd0,
				(beta_q > lpso_pkg::BETA_FLOOR) ? beta_q : lpso_pkg::BETA_FLOOR};
			lpso_pkg::I_EXPB: begin
				iter_req.op = lpso_pkg::OP_EXP;
				iter_req.a  = lpm_q + mn2_q + lpso_pkg::mul16(lb_q, pm1) + lpso_pkg::LOG_30;
				iter_req.b  = lpso_pkg::CAP_TERM;
			end
			default: call = 1'b0;
		endcase
		iter_req.start = call && !pend_q;
	end

	always_comb begin
		state_n = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			lpso_pkg::ST_IDLE: begin
				if (dirty_q) begin
					state_n = lpso_pkg::C_LGM;
				end else if (q_valid) begin
					q_pop   = 1'b1;
					state_n = lpso_pkg::I_SQRT;
				end
			end
			lpso_pkg::C_LGM:   if (iter_rsp.done) state_n = lpso_pkg::C_LGD;
			lpso_pkg::C_LGD:   if (iter_rsp.done) state_n = lpso_pkg::C_DIV;
			lpso_pkg::C_DIV:   if (iter_rsp.done) state_n = lpso_pkg::C_ALPHA;
			lpso_pkg::C_ALPHA:
				if (iter_rsp.done) state_n = p_zero ? lpso_pkg::ST_IDLE : lpso_pkg::C_LGP;
			lpso_pkg::C_LGP:   if (iter_rsp.done) state_n = lpso_pkg::C_EXPT;
			lpso_pkg::C_EXPT:  if (iter_rsp.done) state_n = lpso_pkg::ST_IDLE;
			lpso_pkg::I_SQRT:  if (iter_rsp.done) state_n = lpso_pkg::I_CMP;
			lpso_pkg::I_CMP: begin
				if (zero_hit)               state_n = lpso_pkg::ST_IDLE;
				else if (alpha_q >= norm_q) state_n = lpso_pkg::I_LGN;
				else                        state_n = lpso_pkg::I_DIV;
			end
			lpso_pkg::I_DIV:   if (iter_rsp.done) state_n = lpso_pkg::I_LGN;
			lpso_pkg::I_LGN:   if (iter_rsp.done) state_n = lpso_pkg::I_MN;
			lpso_pkg::I_MN:    state_n = p_zero ? lpso_pkg::I_OUT : lpso_pkg::I_LGB;
			lpso_pkg::I_LGB:   if (iter_rsp.done) state_n = lpso_pkg::I_EXPB;
			lpso_pkg::I_EXPB:
				if (iter_rsp.done)
					state_n = (step_q == SW'(BETA_STEPS - 1)) ? lpso_pkg::I_OUT : lpso_pkg::I_LGB;
			lpso_pkg::I_OUT:   state_n = lpso_pkg::ST_IDLE;
			default:           state_n = lpso_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpso_pkg::ST_IDLE;
			dirty_q <= 1'b1;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			dirty_q <= cfg_wr || (dirty_q && state_q != lpso_pkg::ST_IDLE);
			if (iter_rsp.done)
				pend_q <= 1'b0;
			else if (iter_req.start)
				pend_q <= 1'b1;
			done_q <= (state_q == lpso_pkg::I_OUT) || (state_q == lpso_pkg::I_CMP && zero_hit);
			if (state_q == lpso_pkg::I_MN)
				step_q <= '0;
			else if (state_q == lpso_pkg::I_EXPB && iter_rsp.done)
				step_q <= step_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_head;
		unique case (state_q)
			lpso_pkg::C_LGM:  if (iter_rsp.done) lgm_q <= $signed(rv);
			lpso_pkg::C_LGD:
				if (iter_rsp.done) n_q <= $signed(lpso_pkg::LOG_ONE + rv) - lgm_q;
			lpso_pkg::C_DIV:
				if (iter_rsp.done) la_q <= n_q[63] ? -$signed(rv) : $signed(rv);
			lpso_pkg::C_ALPHA: if (iter_rsp.done) begin
				alpha_q <= rv;
				thr_q   <= rv;
				lpm_q   <= '0;
			end
			lpso_pkg::C_LGP:  if (iter_rsp.done) lpm_q <= $signed(rv) - lgm_q;
			lpso_pkg::C_EXPT: if (iter_rsp.done) thr_q <= alpha_q + rv;
			lpso_pkg::I_SQRT: if (iter_rsp.done) norm_q <= rv;
			lpso_pkg::I_CMP: begin
				if (zero_hit)
					result_q <= '{out_x: '0, out_y: '0, out_z: '0, zeroed: 1'b1};
				else if (alpha_q >= norm_q)
					beta_q <= lpso_pkg::BETA_ONE;
			end
			lpso_pkg::I_DIV:  if (iter_rsp.done) beta_q <= rv[30:0];
			lpso_pkg::I_LGN:
				if (iter_rsp.done) lnorm_q <= $signed(rv) - $signed(lpso_pkg::LOG_16);
			lpso_pkg::I_MN: begin
				mn2_q <= lpso_pkg::mul16(lnorm_q, pm2);
				if (p_zero)
					beta_q <= lpso_pkg::BETA_ONE;
			end
			lpso_pkg::I_LGB:
				if (iter_rsp.done) lb_q <= $signed(rv) - $signed(lpso_pkg::LOG_30);
			lpso_pkg::I_EXPB:
				if (iter_rsp.done)
					beta_q <= (term >= {33'd0, lpso_pkg::BETA_ONE}) ? '0
						: lpso_pkg::BETA_ONE - term[30:0];
			lpso_pkg::I_OUT: begin
				result_q.out_x  <= item_q.neg[0] ? -rmag[0][DW-1:0] : rmag[0][DW-1:0];
				result_q.out_y  <= item_q.neg[1] ? -rmag[1][DW-1:0] : rmag[1][DW-1:0];
				result_q.out_z  <= item_q.neg[2] ? -rmag[2][DW-1:0] : rmag[2][DW-1:0];
				result_q.zeroed <= 1'b0;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/lpso_checker.sv
`include "lp_shrink_operator_unit_macros.svh"

module lpso_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              done,
	input lpso_pkg::result_t result
);

	// a zeroed item carries an all-zero vector
	`LPSO_ASSERT_IMP(a_zero_payload, done && result.zeroed, result.out_x == '0 && result.out_y == '0 && result.out_z == '0, "zeroed item with nonzero vector")

	// the back end never finishes two items in consecutive cycles
	`LPSO_ASSERT_NXT(a_done_gap, done, !done, "results in consecutive cycles")

	// coming out of reset the queue is not full and no result is signalled
	`LPSO_ASSERT_IMP(a_reset_clear, !$past(arst_n), !busy && !done, "not clear after reset")

endmodule

bind lp_shrink_operator_unit lpso_checker u_lpso_checker (.*);

>>> tb/sv/tb_lp_shrink_operator_unit.sv
`timescale 1ns / 1ps

class shrink_scoreboard;
	localparam longint unsigned LG_UNIT = 64'h1_0000_0000;
	localparam longint unsigned B_ONE   = 64'h4000_0000;
	localparam longint unsigned B_MIN   = 64'd11;
	localparam longint unsigned SAT_Q16 = 64'h1_0000_0000_0000;
	localparam longint unsigned SAT_B   = 64'h8000_0000;

	logic [15:0]        p_exp;
	logic [31:0]        mu;
	lpso_pkg::result_t  expected_q[$];
	int                 nbad;

	function new();
		p_exp = lpso_pkg::P_RESET;
		mu    = lpso_pkg::MU_RESET;
		nbad  = 0;
	endfunction

	function void set_reg(logic idx, logic [31:0] wdata);
		if (idx == lpso_pkg::CFG_P_EXP)
			p_exp = wdata[15:0];
		else
			mu = wdata;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 with 32 fraction bits
	function automatic longint log2_q32(longint unsigned u);
		int k;
		longint unsigned x, frac;
		if (u == 0) return 0;
		k = 0;
		for (int n = 0; n < 64; n++) if (u[n]) k = n;
		x = (k > 31) ? (u >> (k - 31)) : (u << (31 - k));
		frac = 0;
		for (int n = 0; n < 32; n++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= LG_UNIT) begin
				frac = frac | 1;
				x = x >> 1;
			end
		end
		return longint'((unsigned'(longint'(k)) << 32) + frac);
	endfunction

	// 2^(lg + fb), saturating
	function automatic longint unsigned pow2_sat(longint lg, int fb, longint unsigned cap);
		longint s, i;
		longint unsigned f, m, c, sh, us, im;
		s = lg + longint'(fb) * longint'(LG_UNIT);
		if (s >= 0) begin
			i = s >>> 32;
			f = unsigned'(s) & 64'hFFFF_FFFF;
		end else begin
			us = 64'd0 - unsigned'(s);
			im = (us + 64'hFFFF_FFFF) >> 32;
			i  = -longint'(im);
			f  = (im << 32) - us;
		end
		m = 64'h8000_0000;
		c = LG_UNIT;
		for (int b = 31; b >= 0; b--) begin
			c = floor_sqrt(c << 31);
			if (f[b]) m = (m * c) >> 31;
		end
		if (i < 31) begin
			sh = unsigned'(31 - i);
			return (sh >= 64) ? 64'd0 : (m >> sh);
		end
		sh = unsigned'(i - 31);
		if (sh >= 32) return cap;
		m = m << sh;
		return (m > cap) ? cap : m;
	endfunction

	function automatic longint scale16(longint a, longint f);
		longint unsigned ma, mf, r;
		ma = (a < 0) ? 64'd0 - unsigned'(a) : unsigned'(a);
		mf = (f < 0) ? 64'd0 - unsigned'(f) : unsigned'(f);
		r  = (ma * mf) >> 16;
		return ((a < 0) != (f < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function void note_item(lpso_pkg::res_t r);
		logic [31:0] comp[3];
		longint unsigned mag[3], sumsq, pv, mv, alpha, thr, norm, beta, d, mn, q, bb, term, o;
		logic neg[3];
		longint lg_mu, nn, la, lpm, lnorm, pm1, pm2, lb;
		lpso_pkg::result_t e;
		comp[0] = r.res_x;
		comp[1] = r.res_y;
		comp[2] = r.res_z;
		sumsq = 0;
		for (int j = 0; j < 3; j++) begin
			neg[j] = comp[j][31];
			mag[j] = neg[j] ? (64'h1_0000_0000 - comp[j]) : {32'd0, comp[j]};
			sumsq  = sumsq + mag[j] * mag[j];
		end
		pv = p_exp;
		mv = (mu == 0) ? 64'd1 : {32'd0, mu};
		lg_mu = log2_q32(mv);
		nn = longint'(LG_UNIT) + log2_q32(65536 - pv) - lg_mu;
		d  = 131072 - pv;
		mn = (nn < 0) ? 64'd0 - unsigned'(nn) : unsigned'(nn);
		q  = (mn << 16) / d;
		la = (nn < 0) ? -longint'(q) : longint'(q);
		pm1 = longint'(pv) - 65536;
		pm2 = longint'(pv) - 131072;
		alpha = pow2_sat(la, 16, SAT_Q16);
		thr = alpha;
		lpm = 0;
		if (pv != 0) begin
			lpm = log2_q32(pv) - lg_mu;
			thr = thr + pow2_sat(lpm + scale16(la, pm1), 16, SAT_Q16);
		end
		norm = floor_sqrt(sumsq);
		e = '0;
		if (norm == 0 || norm <= thr) begin
			e.zeroed = 1'b1;
		end else begin
			beta = (alpha >= norm) ? B_ONE : ((alpha << 30) / norm);
			lnorm = log2_q32(norm) - 16 * longint'(LG_UNIT);
			for (int t = 0; t < lpso_pkg::BETA_STEPS; t++) begin
				bb = (beta > B_MIN) ? beta : B_MIN;
				term = 0;
				if (pv != 0) begin
					lb = log2_q32(bb) - 30 * longint'(LG_UNIT);
					term = pow2_sat(lpm + scale16(lnorm, pm2) + scale16(lb, pm1), 30, SAT_B);
				end
				beta = (term >= B_ONE) ? 64'd0 : (B_ONE - term);
			end
			for (int j = 0; j < 3; j++) begin
				o = (mag[j] * beta + (B_ONE >> 1)) >> 30;
				comp[j] = neg[j] ? (32'd0 - o[31:0]) : o[31:0];
			end
			e.out_x = comp[0];
			e.out_y = comp[1];
			e.out_z = comp[2];
		end
		expected_q.push_back(e);
	endfunction

	function void check_result(lpso_pkg::result_t a);
		lpso_pkg::result_t e;
		if (expected_q.size() == 0) begin
			$error("result with no item outstanding: %h", a);
			nbad++;
			return;
		end
		e = expected_q.pop_front();
		if (a.out_x !== e.out_x) begin
			$error("out_x expected %h actual %h", e.out_x, a.out_x);
			nbad++;
		end
		if (a.out_y !== e.out_y) begin
			$error("out_y expected %h actual %h", e.out_y, a.out_y);
			nbad++;
		end
		if (a.out_z !== e.out_z) begin
			$error("out_z expected %h actual %h", e.out_z, a.out_z);
			nbad++;
		end
		if (a.zeroed !== e.zeroed) begin
			$error("zeroed expected %b actual %b", e.zeroed, a.zeroed);
			nbad++;
		end
	endfunction
endclass

module tb_lp_shrink_operator_unit;
	localparam int STALL_LIMIT = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	lpso_pkg::res_t    res = '0;
	logic              done;
	lpso_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic              cfg_idx = lpso_pkg::CFG_P_EXP;
	logic [31:0]       cfg_wdata = '0;

	shrink_scoreboard sb = new();
	int  quiet_cycles = 0;
	bit  no_gaps = 0;

	lp_shrink_operator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .res(res),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
		if (arst_n && ((start && !busy) || done))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		res = '{res_x: x, res_y: y, res_z: z};
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.note_item(res);
	endtask

	task automatic write_reg(logic idx, logic [31:0] wdata);
		@(negedge clk);
		start = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = wdata;
		sb.set_reg(idx, wdata);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// component spread over zero, near threshold, mid range, full range and the extreme values
	function automatic logic [31:0] pick_comp();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'd0;
			1: v = $urandom_range(0, 120000);
			2: v = $urandom >> $urandom_range(0, 31);
			3: v = $urandom;
			4: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: v = $urandom_range(0, 4000000);
		endcase
		if (v != 32'h8000_0000 && $urandom_range(0, 1)) v = 32'd0 - v;
		return v;
	endfunction

	task automatic random_items(int n);
		for (int k = 0; k < n; k++) begin
			if (k % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				send_item(pick_comp(), 32'd0, 32'd0);
			else
				send_item(pick_comp(), pick_comp(), pick_comp());
		end
		no_gaps = 0;
	endtask

	logic [15:0] p_set[8] = '{16'd26214, 16'd65535, 16'd1, 16'd0, 16'd32768, 0, 0, 0};
	logic [31:0] mu_set[8] = '{32'd655360, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd65536, 0, 0, 0};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items at reset settings
		send_item(32'd0, 32'd0, 32'd0);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(32'h8000_0000, 32'd0, 32'd0);
		send_item(32'h7FFF_FFFF, 32'd0, 32'd0);
		send_item(32'd1, 32'd0, 32'd0);
		send_item(32'hFFFF_FFFF, 32'd0, 32'd0);
		send_item(32'd17000, 32'd0, 32'd0);
		send_item(32'd30000, 32'd0, 32'd0);
		send_item(-32'sd40000, 32'd20000, 32'd0);
		send_item(32'd65536, -32'sd65536, 32'd65536);
		send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
		send_item(32'd0, 32'd0, 32'h0001_0000);
		send_item(32'd0, -32'sd200000, 32'd0);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph >= 5) begin
				p_set[ph]  = $urandom_range(1, 65535);
				mu_set[ph] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2000000);
			end
			write_reg(lpso_pkg::CFG_P_EXP, {16'($urandom), p_set[ph]});
			write_reg(lpso_pkg::CFG_MU, mu_set[ph]);
			if (ph == 3) begin
				send_item(32'd0, 32'd0, 32'd0);
				send_item(32'h7FFF_FFFF, 32'd0, 32'd0);
			end
			random_items(85);
		end

		@(negedge clk);
		start = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.nbad == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
